FILE: rtl/pfs_pkg.sv
`timescale 1ns / 1ps
// Shared types, fixed-point constants and lookup functions for the potential-field steering unit.
// No dependencies.
package pfs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int FW = 52;                   // force component width
	localparam int AW = 36;                   // angle width, Q2.30 with headroom
	localparam int EXP_STAGES = FRAC_BITS + 5; // one stage per usable bit of the exponent
	localparam int LANE_LAT = EXP_STAGES + 2;

	localparam logic [63:0] MIN_RANGE_Q40 = 64'd10995116;
	localparam logic [23:0] RANGE_THR = 24'(MIN_RANGE_Q40 >> (40 - FRAC_BITS));
	localparam logic [63:0] GOAL_SQ_Q60 = 64'd11529215046068470;
	localparam logic [2*FRAC_BITS+1:0] GOAL_SQ_LIM =
		(2*FRAC_BITS+2)'(((GOAL_SQ_Q60 - 64'd1) >> (60 - 2*FRAC_BITS)) + 64'd1);

	localparam logic [30:0] Q30_ONE = 31'd1073741824;
	localparam logic signed [AW-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [30:0] INV_GAIN_Q30 = 31'd652032874;
	localparam logic [29:0] COS30_Q30 = 30'd929887697;

	typedef struct packed {
		logic                vld;
		logic                at_goal;
		logic signed [18:0]  heading;
	} side_t;

	// exp(-2^(idx-24)) in Q2.30
	function automatic logic [30:0] exp_q30(input int idx);
		logic [30:0] v;
		unique case (idx)
			0: v = 31'd1073741760;
			1: v = 31'd1073741696;
			2: v = 31'd1073741568;
			3: v = 31'd1073741312;
			4: v = 31'd1073740800;
			5: v = 31'd1073739776;
			6: v = 31'd1073737728;
			7: v = 31'd1073733632;
			8: v = 31'd1073725440;
			9: v = 31'd1073709056;
			10: v = 31'd1073676290;
			11: v = 31'd1073610760;
			12: v = 31'd1073479712;
			13: v = 31'd1073217664;
			14: v = 31'd1072693760;
			15: v = 31'd1071646719;
			16: v = 31'd1069555701;
			17: v = 31'd1065385899;
			18: v = 31'd1057095000;
			19: v = 31'd1040706261;
			20: v = 31'd1008687096;
			21: v = 31'd947573834;
			22: v = 31'd836230973;
			23: v = 31'd651257337;
			24: v = 31'd395007542;
			25: v = 31'd145315154;
			26: v = 31'd19666268;
			27: v = 31'd360200;
			28: v = 31'd121;
			default: v = '0;
		endcase
		return v;
	endfunction

	// atan(2^-i) in Q2.30
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] v;
		unique case (i)
			0: v = 30'd843314857;
			1: v = 30'd497837829;
			2: v = 30'd263043837;
			3: v = 30'd133525159;
			4: v = 30'd67021687;
			5: v = 30'd33543516;
			6: v = 30'd16775851;
			7: v = 30'd8388437;
			8: v = 30'd4194283;
			9: v = 30'd2097149;
			default: v = (i <= 29) ? 30'(64'd1 << (30 - i)) : '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/pfs_repel_lane.sv
`timescale 1ns / 1ps
// One sensor lane: scaled range, pipelined exp(-x) chain and repulsive magnitude.
// Depends on pfs_pkg.
module pfs_repel_lane (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        sensor_valid,
	input  logic [23:0] sensor_range,
	input  logic [31:0] repel_gain,
	input  logic [31:0] inverse_falloff,
	output logic [31:0] mag
);
	localparam int F = pfs_pkg::FRAC_BITS;
	localparam int E = pfs_pkg::EXP_STAGES;

	logic [55:0]  prod;
	logic [E-1:0] x_s1;
	logic         act_s1;

	logic [30:0]  acc_q [E];
	logic [E-1:0] xb_q  [E];
	logic         act_q [E];

	logic [30:0]      acc_rnd;
	logic [F:0]       e_val;
	logic [F+32:0]    mag_prod;

	assign prod = 56'(sensor_range) * 56'(inverse_falloff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else if (en) begin
			// drop the sensor on a tiny range or an exponent too large for the table
			act_s1 <= sensor_valid && (sensor_range > pfs_pkg::RANGE_THR) && !(|prod[55:F+E]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= prod[F+E-1:F];
		end
	end

	genvar k;
	generate
		for (k = 0; k < E; k++) begin : g_exp
			localparam logic [30:0] TBL = pfs_pkg::exp_q30(k - F + 24);
			logic [30:0]  acc_in;
			logic [E-1:0] x_in;
			logic         act_in;
			logic [61:0]  p;
			if (k == 0) begin : g_first
				assign acc_in = pfs_pkg::Q30_ONE;
				assign x_in   = x_s1;
				assign act_in = act_s1;
			end else begin : g_next
				assign acc_in = acc_q[k-1];
				assign x_in   = xb_q[k-1];
				assign act_in = act_q[k-1];
			end
			assign p = 62'(acc_in) * 62'(TBL) + 62'(64'd1 << 29);

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					act_q[k] <= 1'b0;
				end else if (en) begin
					act_q[k] <= act_in;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					acc_q[k] <= x_in[k] ? p[60:30] : acc_in;
					xb_q[k]  <= x_in;
				end
			end
		end
	endgenerate

	always_comb begin
		acc_rnd  = acc_q[E-1] + 31'(64'd1 << (29 - F));
		e_val    = acc_rnd[30:30-F];
		mag_prod = (F+33)'(repel_gain) * (F+33)'(e_val);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag <= act_q[E-1] ? mag_prod[F+31:F] : 32'd0;
		end
	end

endmodule

FILE: rtl/pfs_merge.sv
`timescale 1ns / 1ps
// Combines the three lane magnitudes with the attractive force into one force vector.
// Depends on pfs_pkg.
module pfs_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [31:0]                    mag_left,
	input  logic [31:0]                    mag_front,
	input  logic [31:0]                    mag_right,
	input  logic signed [pfs_pkg::FW-1:0]  fx_att,
	input  logic signed [pfs_pkg::FW-1:0]  fy_att,
	input  pfs_pkg::side_t                 side_in,
	output logic signed [pfs_pkg::FW-1:0]  fx,
	output logic signed [pfs_pkg::FW-1:0]  fy,
	output pfs_pkg::side_t                 side_out
);
	localparam int FW = pfs_pkg::FW;

	logic [61:0] pl, pr;
	logic [31:0] cl_s1, cr_s1, mf_s1, hl_s1, hr_s1;
	logic signed [FW-1:0] fxa_s1, fya_s1;
	pfs_pkg::side_t side_s1;

	assign pl = 62'(mag_left) * 62'(pfs_pkg::COS30_Q30);
	assign pr = 62'(mag_right) * 62'(pfs_pkg::COS30_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_out <= '0;
		end else if (en) begin
			side_s1  <= side_in;
			side_out <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cl_s1  <= pl[61:30];
			cr_s1  <= pr[61:30];
			mf_s1  <= mag_front;
			hl_s1  <= mag_left >> 1;
			hr_s1  <= mag_right >> 1;
			fxa_s1 <= fx_att;
			fya_s1 <= fy_att;
			// side sensors push along -x by cos30 and sideways by sin30
			fx <= fxa_s1 - FW'(mf_s1) - FW'(cl_s1) - FW'(cr_s1);
			fy <= fya_s1 - FW'(hl_s1) + FW'(hr_s1);
		end
	end

endmodule

FILE: rtl/pfs_atan.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: force angle, minus heading, wrapped into [-pi, pi].
// Depends on pfs_pkg.
module pfs_atan #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic signed [pfs_pkg::FW-1:0]  fx,
	input  logic signed [pfs_pkg::FW-1:0]  fy,
	input  pfs_pkg::side_t                 side_in,
	output logic signed [pfs_pkg::AW-1:0]  err,
	output pfs_pkg::side_t                 side_out
);
	localparam int CW = pfs_pkg::FW + 4;
	localparam int AW = pfs_pkg::AW;

	logic signed [CW-1:0] x_q [STAGES+1];
	logic signed [CW-1:0] y_q [STAGES+1];
	logic signed [AW-1:0] z_q [STAGES+1];
	logic                 zero_q [STAGES+1];
	pfs_pkg::side_t       side_q [STAGES+1];

	logic signed [CW-1:0] fx_e, fy_e;
	logic signed [AW-1:0] e0_s1;
	pfs_pkg::side_t       side_s1;

	assign fx_e = CW'(fx);
	assign fy_e = CW'(fy);

	// pre-rotate the left half-plane by pi
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q[0] <= '0;
		end else if (en) begin
			side_q[0] <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (fx == '0) && (fy == '0);
			if (fx < 0) begin
				x_q[0] <= -fx_e;
				y_q[0] <= -fy_e;
				z_q[0] <= (fy >= 0) ? pfs_pkg::PI_Q30 : -pfs_pkg::PI_Q30;
			end else begin
				x_q[0] <= fx_e;
				y_q[0] <= fy_e;
				z_q[0] <= '0;
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			localparam logic signed [AW-1:0] STEP = AW'(pfs_pkg::atan_q30(i));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_q[i+1] <= '0;
				end else if (en) begin
					side_q[i+1] <= side_q[i];
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					zero_q[i+1] <= zero_q[i];
					if (y_q[i] >= 0) begin
						x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] + STEP;
					end else begin
						x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] - STEP;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1  <= '0;
			side_out <= '0;
		end else if (en) begin
			side_s1  <= side_q[STAGES];
			side_out <= side_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s1 <= (zero_q[STAGES] ? AW'(0) : z_q[STAGES])
				- (AW'(side_q[STAGES].heading) <<< (30 - pfs_pkg::FRAC_BITS));
			priority if (e0_s1 > pfs_pkg::PI_Q30) begin
				err <= e0_s1 - (pfs_pkg::PI_Q30 <<< 1);
			end else if (e0_s1 < -pfs_pkg::PI_Q30) begin
				err <= e0_s1 + (pfs_pkg::PI_Q30 <<< 1);
			end else begin
				err <= e0_s1;
			end
		end
	end

endmodule

FILE: rtl/pfs_cos.sv
`timescale 1ns / 1ps
// Pipelined rotation CORDIC giving cos of the heading error, clamped to [0, 1] in Q2.30.
// Depends on pfs_pkg.
module pfs_cos #(
	parameter int STAGES = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic signed [pfs_pkg::AW-1:0]  angle,
	output logic [30:0]                    cos_val
);
	localparam int AW = pfs_pkg::AW;
	localparam int XW = 34;

	logic signed [XW-1:0] x_q [STAGES+1];
	logic signed [XW-1:0] y_q [STAGES+1];
	logic signed [AW-1:0] z_q [STAGES+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= XW'(pfs_pkg::INV_GAIN_Q30);
			y_q[0] <= '0;
			z_q[0] <= angle;
		end
	end

	genvar i;
	generate
		for (i = 0; i < STAGES; i++) begin : g_stage
			localparam logic signed [AW-1:0] STEP = AW'(pfs_pkg::atan_q30(i));
			always_ff @(posedge clk) begin
				if (en) begin
					if (z_q[i] >= 0) begin
						x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] - STEP;
					end else begin
						x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
						y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
						z_q[i+1] <= z_q[i] + STEP;
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (x_q[STAGES] < 0) begin
				cos_val <= '0;
			end else if (x_q[STAGES] > XW'(pfs_pkg::Q30_ONE)) begin
				cos_val <= pfs_pkg::Q30_ONE;
			end else begin
				cos_val <= x_q[STAGES][30:0];
			end
		end
	end

endmodule

FILE: rtl/potential_field_steering_unit.sv
`timescale 1ns / 1ps
// Potential-field steering top level: attraction, three repulsion lanes, merge, CORDICs, output.
// Depends on pfs_pkg, pfs_repel_lane, pfs_merge, pfs_atan, pfs_cos.
//
//  port group  | direction | carries
//  s_axis_*    | in        | rover pose, goal and three IR ranges per transaction
//  m_axis_*    | out       | speed, turn rate and at-goal flag per transaction
//  cfg_*       | in        | gain and limit register writes
//
// One transaction per cycle while s_axis_tready is high; the pipeline depth is set by the
// exponential chain in each lane and the two CORDIC pipelines.
// Every stage moves together; a two-entry output buffer (output register plus skid)
// lets the pipe run while a result waits, and s_axis_tready drops only when both hold.
// Reset clears valid flags and loads the register defaults.
module potential_field_steering_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// pos_x, pos_y, heading, goal_x, goal_y, left_valid, left_range,
	// front_valid, front_range, right_valid, right_range, zero pad
	input  logic [223:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// speed, turn_rate, at_goal
	output logic [63:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int F   = pfs_pkg::FRAC_BITS;
	localparam int FW  = pfs_pkg::FW;
	localparam int AW  = pfs_pkg::AW;
	localparam int SQW = 2 * F;
	localparam int D1  = pfs_pkg::LANE_LAT - 3;
	localparam int D2  = CORDIC_STAGES;

	localparam logic [2:0] REG_ATTRACT = 3'd0;
	localparam logic [2:0] REG_REPEL   = 3'd1;
	localparam logic [2:0] REG_FALLOFF = 3'd2;
	localparam logic [2:0] REG_HEADING = 3'd3;
	localparam logic [2:0] REG_TURNLIM = 3'd4;
	localparam logic [2:0] REG_SPEEDLIM = 3'd5;

	typedef struct packed {
		pfs_pkg::side_t        side;
		logic signed [FW-1:0]  fx;
		logic signed [FW-1:0]  fy;
	} att_t;

	typedef struct packed {
		pfs_pkg::side_t        side;
		logic                  back;
		logic signed [31:0]    omega;
	} steer_t;

	// configuration registers
	logic [31:0] attract_gain_q, repel_gain_q, inverse_falloff_q, heading_gain_q;
	logic [30:0] turn_rate_limit_q, speed_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attract_gain_q    <= 32'd65536;
			repel_gain_q      <= 32'd65536;
			inverse_falloff_q <= 32'd65536;
			heading_gain_q    <= 32'd65536;
			turn_rate_limit_q <= 31'd65536;
			speed_limit_q     <= 31'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ATTRACT:  attract_gain_q    <= cfg_data;
				REG_REPEL:    repel_gain_q      <= cfg_data;
				REG_FALLOFF:  inverse_falloff_q <= cfg_data;
				REG_HEADING:  heading_gain_q    <= cfg_data;
				REG_TURNLIM:  turn_rate_limit_q <= cfg_data[30:0];
				REG_SPEEDLIM: speed_limit_q     <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// input fields
	logic signed [31:0] pos_x, pos_y, goal_x, goal_y;
	logic signed [18:0] heading;
	logic               left_valid, front_valid, right_valid;
	logic [23:0]        left_range, front_range, right_range;

	assign pos_x       = s_axis_tdata[31:0];
	assign pos_y       = s_axis_tdata[63:32];
	assign heading     = s_axis_tdata[82:64];
	assign goal_x      = s_axis_tdata[114:83];
	assign goal_y      = s_axis_tdata[146:115];
	assign left_valid  = s_axis_tdata[147];
	assign left_range  = s_axis_tdata[171:148];
	assign front_valid = s_axis_tdata[172];
	assign front_range = s_axis_tdata[196:173];
	assign right_valid = s_axis_tdata[197];
	assign right_range = s_axis_tdata[221:198];

	logic en;
	logic skid_vld_q, out_vld_q;
	logic [63:0] skid_q, out_q;

	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	// attraction and goal test
	pfs_pkg::side_t side_s1, side_s2, side_s3;
	logic signed [32:0] dx_s1, dy_s1;
	logic [32:0] adx, ady;
	logic [64:0] prod_x, prod_y;
	logic signed [FW-1:0] fxa, fya, fxa_s2, fya_s2, fxa_s3, fya_s3;
	logic near_s2;
	logic [SQW-1:0] sqx_s2, sqy_s2;
	logic [SQW+1:0] d2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
			side_s3 <= '0;
		end else if (en) begin
			side_s1.vld     <= s_axis_tvalid;
			side_s1.at_goal <= 1'b0;
			side_s1.heading <= heading;
			side_s2         <= side_s1;
			side_s3.vld     <= side_s2.vld;
			side_s3.heading <= side_s2.heading;
			side_s3.at_goal <= near_s2 && (d2 < pfs_pkg::GOAL_SQ_LIM);
		end
	end

	always_comb begin
		adx    = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
		ady    = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
		prod_x = 65'(adx) * 65'(attract_gain_q);
		prod_y = 65'(ady) * 65'(attract_gain_q);
		fxa    = (dx_s1 > 0) ? -FW'(prod_x[F+48:F]) : FW'(prod_x[F+48:F]);
		fya    = (dy_s1 > 0) ? -FW'(prod_y[F+48:F]) : FW'(prod_y[F+48:F]);
		d2     = (SQW+2)'(sqx_s2) + (SQW+2)'(sqy_s2);
	end

	att_t att_s3;
	att_t dly1_q [D1];

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= 33'(pos_x) - 33'(goal_x);
			dy_s1   <= 33'(pos_y) - 33'(goal_y);
			fxa_s2  <= fxa;
			fya_s2  <= fya;
			near_s2 <= (adx < 33'(64'd1 << F)) && (ady < 33'(64'd1 << F));
			sqx_s2  <= SQW'(adx[F-1:0]) * SQW'(adx[F-1:0]);
			sqy_s2  <= SQW'(ady[F-1:0]) * SQW'(ady[F-1:0]);
			fxa_s3  <= fxa_s2;
			fya_s3  <= fya_s2;
		end
	end

	always_comb begin
		att_s3.side = side_s3;
		att_s3.fx   = fxa_s3;
		att_s3.fy   = fya_s3;
	end

	// align the attraction with the lane outputs
	genvar d;
	generate
		for (d = 0; d < D1; d++) begin : g_dly1
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dly1_q[d] <= '0;
				end else if (en) begin
					dly1_q[d] <= (d == 0) ? att_s3 : dly1_q[(d == 0) ? 0 : d-1];
				end
			end
		end
	endgenerate

	// repulsion lanes
	logic [31:0] mag_left, mag_front, mag_right;

	pfs_repel_lane u_lane_left (
		.clk, .arst_n, .en,
		.sensor_valid(left_valid), .sensor_range(left_range),
		.repel_gain(repel_gain_q), .inverse_falloff(inverse_falloff_q),
		.mag(mag_left)
	);

	pfs_repel_lane u_lane_front (
		.clk, .arst_n, .en,
		.sensor_valid(front_valid), .sensor_range(front_range),
		.repel_gain(repel_gain_q), .inverse_falloff(inverse_falloff_q),
		.mag(mag_front)
	);

	pfs_repel_lane u_lane_right (
		.clk, .arst_n, .en,
		.sensor_valid(right_valid), .sensor_range(right_range),
		.repel_gain(repel_gain_q), .inverse_falloff(inverse_falloff_q),
		.mag(mag_right)
	);

	logic signed [FW-1:0] fx_m, fy_m;
	pfs_pkg::side_t side_m;

	pfs_merge u_merge (
		.clk, .arst_n, .en,
		.mag_left, .mag_front, .mag_right,
		.fx_att(dly1_q[D1-1].fx), .fy_att(dly1_q[D1-1].fy),
		.side_in(dly1_q[D1-1].side),
		.fx(fx_m), .fy(fy_m), .side_out(side_m)
	);

	logic signed [AW-1:0] err_a;
	pfs_pkg::side_t side_a;

	pfs_atan #(.STAGES(CORDIC_STAGES)) u_atan (
		.clk, .arst_n, .en,
		.fx(fx_m), .fy(fy_m), .side_in(side_m),
		.err(err_a), .side_out(side_a)
	);

	logic [30:0] cos_c;

	pfs_cos #(.STAGES(CORDIC_STAGES)) u_cos (
		.clk, .en, .angle(err_a), .cos_val(cos_c)
	);

	// turn rate, in parallel with the cosine
	logic [31:0] aerr;
	logic [63:0] om_prod;
	logic [33:0] om_mag_s4;
	logic        neg_s4, back_s4;
	pfs_pkg::side_t side_s4;
	logic [30:0] om_clamp;
	steer_t steer_s5;
	steer_t dly2_q [D2];

	always_comb begin
		aerr     = err_a[AW-1] ? 32'(-err_a) : 32'(err_a);
		om_prod  = 64'(aerr) * 64'(heading_gain_q);
		om_clamp = (om_mag_s4 > 34'(turn_rate_limit_q)) ? turn_rate_limit_q : om_mag_s4[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4  <= '0;
			steer_s5 <= '0;
		end else if (en) begin
			side_s4        <= side_a;
			steer_s5.side  <= side_s4;
			steer_s5.back  <= back_s4;
			steer_s5.omega <= neg_s4 ? -32'(om_clamp) : 32'(om_clamp);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			om_mag_s4 <= om_prod[63:30];
			neg_s4    <= err_a[AW-1];
			back_s4   <= aerr >= pfs_pkg::HALF_PI_Q30;
		end
	end

	generate
		for (d = 0; d < D2; d++) begin : g_dly2
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					dly2_q[d] <= '0;
				end else if (en) begin
					dly2_q[d] <= (d == 0) ? steer_s5 : dly2_q[(d == 0) ? 0 : d-1];
				end
			end
		end
	endgenerate

	// final speed product and goal masking
	logic [61:0] sp_prod;
	logic [30:0] speed_r;
	logic [31:0] omega_r;
	logic        goal_r, res_vld;
	logic [63:0] res;

	always_comb begin
		sp_prod = 62'(speed_limit_q) * 62'(cos_c);
		goal_r  = dly2_q[D2-1].side.at_goal;
		res_vld = dly2_q[D2-1].side.vld;
		speed_r = (dly2_q[D2-1].back || goal_r) ? 31'd0 : sp_prod[60:30];
		omega_r = goal_r ? 32'd0 : dly2_q[D2-1].omega;
		res     = {goal_r, omega_r, speed_r};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_axis_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= res_vld;
			end
		end else if (res_vld) begin
			// output blocked: park the transaction in the skid stage
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_axis_tready || !out_vld_q) begin
			out_q <= skid_vld_q ? skid_q : res;
		end else if (en && res_vld) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

FILE: rtl/pfs_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the potential-field steering unit, bound to the top level.
// Depends on potential_field_steering_unit.
module pfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// at goal the commands are zeroed
	a_goal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[63] |-> m_axis_tdata[62:0] == 63'd0)
		else $error("at_goal result carries nonzero commands");

	// input backpressure only when a result is already held at the output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// a stalled input stays stalled until the output moves
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready && !m_axis_tready |=> !s_axis_tready)
		else $error("input released without an output transaction");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transaction changed while stalled");

endmodule

bind potential_field_steering_unit pfs_checker u_pfs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
